// File: rtl/crpc_pkg.sv
`timescale 1ns / 1ps
// shared widths, opcodes and controller/datapath command types
package crpc_pkg;

    localparam int COORD_BITS      = 16;
    localparam int DIFF_W          = COORD_BITS + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int SUM_W           = PROD_W + 1;

    localparam int OPCODE_W        = 2;
    localparam int REGION_W        = 2;
    localparam int SLOT_W          = 3;
    localparam int TOTAL_W         = 4;
    localparam int YIELD_W         = 16;
    localparam int INDEX_W         = 2;
    localparam int CFG_W           = 3;

    localparam int DEF_MAX_REGIONS = 4;
    localparam int DEF_MAX_CORNERS = 8;
    localparam int MIN_CORNERS     = 3;

    typedef logic [OPCODE_W-1:0] opcode_t;

    localparam opcode_t OP_WRITE_VERTEX  = 2'd0;
    localparam opcode_t OP_DEFINE_REGION = 2'd1;
    localparam opcode_t OP_QUERY         = 2'd2;
    localparam opcode_t OP_UNUSED        = 2'd3;

    typedef struct packed {
        logic wr_vertex;
        logic wr_region;
        logic load_point;
        logic region_start;
        logic edge_issue;
        logic edge_first;
        logic res_load;
        logic res_found;
    } crpc_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic region_hit;
    } crpc_stat_t;

endpackage

// File: rtl/crpc_intf.sv
`timescale 1ns / 1ps
// handshake interfaces for the item, result and configuration channels
interface crpc_item_if;
    import crpc_pkg::*;

    logic                          valid;
    logic                          ready;
    opcode_t                       opcode;
    logic [REGION_W-1:0]           region;
    logic [SLOT_W-1:0]             vertex_slot;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic [TOTAL_W-1:0]            corner_total;
    logic [YIELD_W-1:0]            yield_value;

    modport source (
        output valid, opcode, region, vertex_slot, coord_x, coord_y, corner_total,
               yield_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, region, vertex_slot, coord_x, coord_y, corner_total,
               yield_value,
        output ready
    );
endinterface

interface crpc_result_if;
    import crpc_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] region_index;
    logic [YIELD_W-1:0] region_yield;

    modport source (
        output valid, found, region_index, region_yield,
        input  ready
    );
    modport sink (
        input  valid, found, region_index, region_yield,
        output ready
    );
endinterface

interface crpc_cfg_if;
    import crpc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: rtl/crpc_datapath.sv
`timescale 1ns / 1ps
// vertex memory, region table and the edge test pipeline
module crpc_datapath #(
    parameter int MAX_REGIONS = crpc_pkg::DEF_MAX_REGIONS,
    parameter int MAX_CORNERS = crpc_pkg::DEF_MAX_CORNERS,
    parameter int RIDX_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
    parameter int CIDX_W      = $clog2(MAX_CORNERS),
    parameter int CCNT_W      = $clog2(MAX_CORNERS + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  crpc_pkg::crpc_cmd_t                     cmd,
    output crpc_pkg::crpc_stat_t                    stat,
    input  logic [RIDX_W-1:0]                       region_sel,
    input  logic [CIDX_W-1:0]                       corner_sel,
    output logic [CCNT_W-1:0]                       corner_count,
    input  logic [crpc_pkg::REGION_W-1:0]           region,
    input  logic [crpc_pkg::SLOT_W-1:0]             vertex_slot,
    input  logic signed [crpc_pkg::COORD_BITS-1:0]  coord_x,
    input  logic signed [crpc_pkg::COORD_BITS-1:0]  coord_y,
    input  logic [crpc_pkg::TOTAL_W-1:0]            corner_total,
    input  logic [crpc_pkg::YIELD_W-1:0]            yield_value,
    output logic                                    found,
    output logic [crpc_pkg::INDEX_W-1:0]            region_index,
    output logic [crpc_pkg::YIELD_W-1:0]            region_yield
);
    import crpc_pkg::*;

    localparam int DEPTH  = MAX_REGIONS * MAX_CORNERS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TW     = (TOTAL_W > CCNT_W) ? TOTAL_W : CCNT_W;

    logic signed [COORD_BITS-1:0] corner_x_mem [DEPTH];
    logic signed [COORD_BITS-1:0] corner_y_mem [DEPTH];

    logic [CCNT_W-1:0]  count_reg [MAX_REGIONS];
    logic [YIELD_W-1:0] yield_reg [MAX_REGIONS];

    logic                         region_ok;
    logic                         slot_ok;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ADDR_W-1:0]            rd_addr;
    logic [RIDX_W-1:0]            wr_ridx;
    logic [CCNT_W-1:0]            total_sat;
    logic                         sel_ok;

    logic                         rd_vld_reg;
    logic                         rd_first_reg;
    logic signed [COORD_BITS-1:0] rd_x_reg;
    logic signed [COORD_BITS-1:0] rd_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;

    logic                         eg_vld_reg;
    logic signed [DIFF_W-1:0]     ex_reg;
    logic signed [DIFF_W-1:0]     ey_reg;
    logic signed [DIFF_W-1:0]     dx_reg;
    logic signed [DIFF_W-1:0]     dy_reg;

    logic                         mu_vld_reg;
    logic signed [PROD_W-1:0]     p_exdy_reg;
    logic signed [PROD_W-1:0]     p_eydx_reg;
    logic signed [PROD_W-1:0]     p_dxex_reg;
    logic signed [PROD_W-1:0]     p_dyey_reg;
    logic signed [PROD_W-1:0]     p_exex_reg;
    logic signed [PROD_W-1:0]     p_eyey_reg;

    logic                         sm_vld_reg;
    logic signed [SUM_W-1:0]      cross_reg;
    logic signed [SUM_W-1:0]      dot_reg;
    logic signed [SUM_W-1:0]      len2_reg;

    logic                         neg_reg;
    logic                         pos_reg;
    logic                         decided_reg;
    logic                         verdict_reg;

    logic                         cross_zero;
    logic                         cross_neg;
    logic                         on_seg;
    logic                         neg_next;
    logic                         pos_next;

    logic                         found_reg;
    logic [INDEX_W-1:0]           index_reg;
    logic [YIELD_W-1:0]           ryield_reg;

    assign region_ok = 32'(region) < 32'(MAX_REGIONS);
    assign slot_ok   = 32'(vertex_slot) < 32'(MAX_CORNERS);
    assign wr_ridx   = RIDX_W'(region);
    assign wr_addr   = ADDR_W'(32'(region) * MAX_CORNERS + 32'(vertex_slot));
    assign rd_addr   = ADDR_W'(32'(region_sel) * MAX_CORNERS + 32'(corner_sel));
    assign total_sat = (TW'(corner_total) > TW'(MAX_CORNERS)) ? CCNT_W'(MAX_CORNERS)
                                                              : CCNT_W'(corner_total);
    assign sel_ok       = 32'(region_sel) < 32'(MAX_REGIONS);
    assign corner_count = sel_ok ? count_reg[region_sel] : '0;

    // vertex memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_vertex && region_ok && slot_ok)
        begin
            corner_x_mem[wr_addr] <= coord_x;
            corner_y_mem[wr_addr] <= coord_y;
        end
        if (cmd.edge_issue)
        begin
            rd_x_reg <= corner_x_mem[rd_addr];
            rd_y_reg <= corner_y_mem[rd_addr];
        end
    end

    assign cross_zero = (cross_reg == '0);
    assign cross_neg  = cross_reg[SUM_W-1];
    assign on_seg     = !dot_reg[SUM_W-1] && (dot_reg <= len2_reg);
    assign neg_next   = neg_reg || cross_neg;
    assign pos_next   = pos_reg || !cross_neg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_REGIONS; i++)
            begin
                count_reg[i] <= '0;
                yield_reg[i] <= '0;
            end
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            eg_vld_reg   <= 1'b0;
            mu_vld_reg   <= 1'b0;
            sm_vld_reg   <= 1'b0;
            neg_reg      <= 1'b0;
            pos_reg      <= 1'b0;
            decided_reg  <= 1'b0;
            verdict_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_region && region_ok)
            begin
                count_reg[wr_ridx] <= total_sat;
                yield_reg[wr_ridx] <= yield_value;
            end
            rd_vld_reg   <= cmd.edge_issue;
            rd_first_reg <= cmd.edge_first;
            eg_vld_reg   <= rd_vld_reg && !rd_first_reg;
            mu_vld_reg   <= eg_vld_reg;
            sm_vld_reg   <= mu_vld_reg;
            // edges resolve in order: on-edge hit or mixed signs settle the region
            if (cmd.region_start)
            begin
                neg_reg     <= 1'b0;
                pos_reg     <= 1'b0;
                decided_reg <= 1'b0;
                verdict_reg <= 1'b0;
            end
            else if (sm_vld_reg && !decided_reg)
            begin
                if (cross_zero)
                begin
                    if (on_seg)
                    begin
                        decided_reg <= 1'b1;
                        verdict_reg <= 1'b1;
                    end
                end
                else
                begin
                    neg_reg <= neg_next;
                    pos_reg <= pos_next;
                    if (neg_next && pos_next)
                    begin
                        decided_reg <= 1'b1;
                        verdict_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        ex_reg     <= DIFF_W'(rd_x_reg) - DIFF_W'(prev_x_reg);
        ey_reg     <= DIFF_W'(rd_y_reg) - DIFF_W'(prev_y_reg);
        dx_reg     <= DIFF_W'(px_reg) - DIFF_W'(prev_x_reg);
        dy_reg     <= DIFF_W'(py_reg) - DIFF_W'(prev_y_reg);
        p_exdy_reg <= ex_reg * dy_reg;
        p_eydx_reg <= ey_reg * dx_reg;
        p_dxex_reg <= dx_reg * ex_reg;
        p_dyey_reg <= dy_reg * ey_reg;
        p_exex_reg <= ex_reg * ex_reg;
        p_eyey_reg <= ey_reg * ey_reg;
        cross_reg  <= SUM_W'(p_exdy_reg) - SUM_W'(p_eydx_reg);
        dot_reg    <= SUM_W'(p_dxex_reg) + SUM_W'(p_dyey_reg);
        len2_reg   <= SUM_W'(p_exex_reg) + SUM_W'(p_eyey_reg);
        if (cmd.res_load)
        begin
            found_reg  <= cmd.res_found;
            index_reg  <= cmd.res_found ? INDEX_W'(region_sel) : '0;
            ryield_reg <= (cmd.res_found && sel_ok) ? yield_reg[region_sel] : '0;
        end
    end

    assign stat.pipe_busy  = rd_vld_reg || eg_vld_reg || mu_vld_reg || sm_vld_reg;
    assign stat.region_hit = decided_reg ? verdict_reg : 1'b1;

    assign found        = found_reg;
    assign region_index = index_reg;
    assign region_yield = ryield_reg;

endmodule

// File: rtl/crpc_controller.sv
`timescale 1ns / 1ps
// sequencer for item decode, region scan and result handoff
module crpc_controller #(
    parameter int MAX_REGIONS = crpc_pkg::DEF_MAX_REGIONS,
    parameter int MAX_CORNERS = crpc_pkg::DEF_MAX_CORNERS,
    parameter int RIDX_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
    parameter int CIDX_W      = $clog2(MAX_CORNERS),
    parameter int CCNT_W      = $clog2(MAX_CORNERS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  crpc_pkg::opcode_t             in_opcode,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cfg_valid,
    input  logic [crpc_pkg::CFG_W-1:0]    cfg_data,
    output logic                          cfg_ready,
    output crpc_pkg::crpc_cmd_t           cmd,
    input  crpc_pkg::crpc_stat_t          stat,
    output logic [RIDX_W-1:0]             region_sel,
    output logic [CIDX_W-1:0]             corner_sel,
    input  logic [CCNT_W-1:0]             corner_count
);
    import crpc_pkg::*;

    localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
    localparam int LIM_W  = (RCNT_W > CFG_W) ? RCNT_W : CFG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REGION,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [LIM_W-1:0]  r_reg, r_next;
    logic [CCNT_W-1:0] k_reg, k_next;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]  riu_reg, riu_next;
    logic [LIM_W-1:0]  limit;
    logic              in_accept;

    assign limit = (LIM_W'(riu_reg) > LIM_W'(MAX_REGIONS)) ? LIM_W'(MAX_REGIONS)
                                                           : LIM_W'(riu_reg);
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign cfg_ready  = 1'b1;
    assign region_sel = r_reg[RIDX_W-1:0];
    assign corner_sel = (k_reg == corner_count) ? '0 : k_reg[CIDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        riu_next       = riu_reg;
        cmd            = '0;

        if (cfg_valid)
        begin
            riu_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_opcode)
                        OP_WRITE_VERTEX:  cmd.wr_vertex = 1'b1;
                        OP_DEFINE_REGION: cmd.wr_region = 1'b1;
                        OP_QUERY:
                        begin
                            cmd.load_point = 1'b1;
                            r_next         = '0;
                            state_next     = ST_REGION;
                        end
                        OP_UNUSED: ;
                    endcase
                end
            end
            ST_REGION:
            begin
                if (r_reg >= limit)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (corner_count < CCNT_W'(MIN_CORNERS))
                begin
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    cmd.region_start = 1'b1;
                    k_next           = '0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // wrap back to the first vertex to close the polygon
                cmd.edge_issue = 1'b1;
                cmd.edge_first = (k_reg == '0);
                k_next         = k_reg + 1'b1;
                if (k_reg == corner_count)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    if (stat.region_hit)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_REGION;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_found  = hit_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            k_reg         <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            riu_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            k_reg         <= k_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            riu_reg       <= riu_next;
        end
    end

    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.region_start |-> !stat.pipe_busy)
        else $error("region scan started with edges still in flight");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_opcode == OP_QUERY) |=> !in_ready)
        else $error("input still open after a query beat");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.res_found) |-> (r_reg < limit))
        else $error("hit reported for a region outside the tested range");

    a_scan_enough: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.edge_issue |-> (corner_count >= CCNT_W'(MIN_CORNERS)))
        else $error("edge read for a region with too few vertices");

endmodule

// File: rtl/convex_region_point_classifier.sv
`timescale 1ns / 1ps
// A point query walks the regions in order; a region with n >= 3 vertices
// takes a setup step, n + 1 reads from the vertex memory, one vertex a
// cycle with a wrap back to the first, then a drain of the edge pipeline
// of differences, products, sums and sign check; a region with fewer
// vertices is skipped, and the final decision and the result register
// follow. The search stops at the first containing region. The result
// register frees the input for the next beat while a result waits. Vertex
// storage has no reset; query only regions whose vertices were written.
module convex_region_point_classifier #(
    parameter int MAX_REGIONS = crpc_pkg::DEF_MAX_REGIONS,
    parameter int MAX_CORNERS = crpc_pkg::DEF_MAX_CORNERS
) (
    input  logic          clk,
    input  logic          rst_n,
    crpc_item_if.sink     item_in,
    crpc_result_if.source result_out,
    crpc_cfg_if.sink      cfg
);
    import crpc_pkg::*;

    localparam int RIDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CIDX_W = $clog2(MAX_CORNERS);
    localparam int CCNT_W = $clog2(MAX_CORNERS + 1);

    crpc_cmd_t         cmd;
    crpc_stat_t        stat;
    logic [RIDX_W-1:0] region_sel;
    logic [CIDX_W-1:0] corner_sel;
    logic [CCNT_W-1:0] corner_count;

    crpc_controller #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_CORNERS (MAX_CORNERS),
        .RIDX_W      (RIDX_W),
        .CIDX_W      (CIDX_W),
        .CCNT_W      (CCNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (item_in.valid),
        .in_opcode    (item_in.opcode),
        .in_ready     (item_in.ready),
        .out_valid    (result_out.valid),
        .out_ready    (result_out.ready),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .cfg_ready    (cfg.ready),
        .cmd          (cmd),
        .stat         (stat),
        .region_sel   (region_sel),
        .corner_sel   (corner_sel),
        .corner_count (corner_count)
    );

    crpc_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_CORNERS (MAX_CORNERS),
        .RIDX_W      (RIDX_W),
        .CIDX_W      (CIDX_W),
        .CCNT_W      (CCNT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .region_sel   (region_sel),
        .corner_sel   (corner_sel),
        .corner_count (corner_count),
        .region       (item_in.region),
        .vertex_slot  (item_in.vertex_slot),
        .coord_x      (item_in.coord_x),
        .coord_y      (item_in.coord_y),
        .corner_total (item_in.corner_total),
        .yield_value  (item_in.yield_value),
        .found        (result_out.found),
        .region_index (result_out.region_index),
        .region_yield (result_out.region_yield)
    );

endmodule

// File: tb/sv/crpc_result_checker.sv
`timescale 1ns / 1ps
// checker for the region classifier: mirrors region state, predicts queries, compares beats
module crpc_result_checker (
    input  logic   clk,
    input  logic   rst_n,
    crpc_item_if   item_mon,
    crpc_result_if result_mon,
    crpc_cfg_if    cfg_mon,
    output int     mismatches,
    output int     class_backlog
);
    import crpc_pkg::*;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [YIELD_W-1:0] yld;
    } region_class_t;

    localparam int STORE_DEPTH = DEF_MAX_REGIONS * DEF_MAX_CORNERS;

    logic signed [COORD_BITS-1:0] corner_x   [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] corner_y   [STORE_DEPTH];
    logic [TOTAL_W-1:0]           corner_cnt [DEF_MAX_REGIONS];
    logic [YIELD_W-1:0]           region_yld [DEF_MAX_REGIONS];
    logic [CFG_W-1:0]             active_regions;

    region_class_t predicted_classes [$];
    region_class_t oldest_class;

    function automatic logic point_in_region(input int r,
                                             input logic signed [COORD_BITS-1:0] px,
                                             input logic signed [COORD_BITS-1:0] py);
        int n;
        int i;
        int j;
        logic neg;
        logic pos;
        logic signed [COORD_BITS-1:0] ax, ay, bx, by;
        logic signed [DIFF_W-1:0] ex, ey, dx, dy;
        logic signed [SUM_W-1:0] cross_val, dot, len2;
        n = corner_cnt[r];
        neg = 1'b0;
        pos = 1'b0;
        if (n < MIN_CORNERS)
        begin
            return 1'b0;
        end
        for (i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            ax = corner_x[r * DEF_MAX_CORNERS + i];
            ay = corner_y[r * DEF_MAX_CORNERS + i];
            bx = corner_x[r * DEF_MAX_CORNERS + j];
            by = corner_y[r * DEF_MAX_CORNERS + j];
            ex = bx - ax;
            ey = by - ay;
            dx = px - ax;
            dy = py - ay;
            cross_val = ex * dy - ey * dx;
            if (cross_val == 0)
            begin
                dot  = dx * ex + dy * ey;
                len2 = ex * ex + ey * ey;
                if (dot >= 0 && dot <= len2)
                begin
                    return 1'b1;
                end
            end
            else if (cross_val < 0)
            begin
                neg = 1'b1;
            end
            else
            begin
                pos = 1'b1;
            end
            if (neg && pos)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic region_class_t classify_point(input logic signed [COORD_BITS-1:0] px,
                                                     input logic signed [COORD_BITS-1:0] py);
        region_class_t res;
        int lim;
        int r;
        res = '0;
        lim = (active_regions > DEF_MAX_REGIONS) ? DEF_MAX_REGIONS : active_regions;
        for (r = 0; r < lim; r++)
        begin
            if (point_in_region(r, px, py))
            begin
                res.found = 1'b1;
                res.index = r[INDEX_W-1:0];
                res.yld   = region_yld[r];
                return res;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [YIELD_W-1:0] got,
                                   input logic [YIELD_W-1:0] wanted);
        $display("%0t mismatch on %s: got %0h, predicted %0h", $time, what, got, wanted);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEF_MAX_REGIONS; i++)
            begin
                corner_cnt[i] <= '0;
                region_yld[i] <= '0;
            end
            active_regions <= '0;
            predicted_classes.delete();
            mismatches = 0;
            class_backlog <= 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                if (predicted_classes.size() == 0)
                begin
                    report_mismatch("result beat with no query waiting",
                                    result_mon.region_yield, '0);
                end
                else
                begin
                    oldest_class = predicted_classes.pop_front();
                    if (result_mon.found !== oldest_class.found)
                        report_mismatch("found", result_mon.found, oldest_class.found);
                    if (result_mon.region_index !== oldest_class.index)
                        report_mismatch("region_index", result_mon.region_index,
                                        oldest_class.index);
                    if (result_mon.region_yield !== oldest_class.yld)
                        report_mismatch("region_yield", result_mon.region_yield,
                                        oldest_class.yld);
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                active_regions <= cfg_mon.data;
            end
            if (item_mon.valid && item_mon.ready)
            begin
                case (item_mon.opcode)
                    OP_WRITE_VERTEX:
                    begin
                        corner_x[{item_mon.region, item_mon.vertex_slot}] <= item_mon.coord_x;
                        corner_y[{item_mon.region, item_mon.vertex_slot}] <= item_mon.coord_y;
                    end
                    OP_DEFINE_REGION:
                    begin
                        corner_cnt[item_mon.region] <= (item_mon.corner_total > DEF_MAX_CORNERS)
                            ? TOTAL_W'(DEF_MAX_CORNERS) : item_mon.corner_total;
                        region_yld[item_mon.region] <= item_mon.yield_value;
                    end
                    OP_QUERY:
                    begin
                        predicted_classes.insert(predicted_classes.size(),
                                                 classify_point(item_mon.coord_x,
                                                                item_mon.coord_y));
                    end
                    default:
                    begin
                    end
                endcase
            end
            class_backlog <= predicted_classes.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the region classifier: reset, directed and random beats, verdict
module tb_top;
    import crpc_pkg::*;

    localparam int  QUIET_CYCLES = 80;
    localparam int  PHASE_ITEMS  = 112;
    localparam real TWO_PI       = 6.283185307179586;

    logic clk;
    logic rst_n;
    bit   calm = 1'b0;
    int   mismatches;
    int   class_backlog;
    int   items_sent = 0;

    logic [7:0] written [4] = '{default: '0};
    int         mir_x [4][8];
    int         mir_y [4][8];
    int         mir_cnt [4] = '{default: 0};

    crpc_item_if   item_ch ();
    crpc_result_if result_ch ();
    crpc_cfg_if    cfg_ch ();

    convex_region_point_classifier i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    crpc_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_mon      (item_ch),
        .result_mon    (result_ch),
        .cfg_mon       (cfg_ch),
        .mismatches    (mismatches),
        .class_backlog (class_backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

    // result side stalls
    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_item(input opcode_t op, input logic [REGION_W-1:0] rg,
                             input logic [SLOT_W-1:0] sl,
                             input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic [TOTAL_W-1:0] tot, input logic [YIELD_W-1:0] yv);
        logic took;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= op;
        item_ch.region       <= rg;
        item_ch.vertex_slot  <= sl;
        item_ch.coord_x      <= x;
        item_ch.coord_y      <= y;
        item_ch.corner_total <= tot;
        item_ch.yield_value  <= yv;
        do
        begin
            @(negedge clk);
            took = item_ch.ready;
            @(posedge clk);
        end
        while (!took);
        case (op)
            OP_WRITE_VERTEX:
            begin
                written[rg][sl] = 1'b1;
                mir_x[rg][sl] = int'(x);
                mir_y[rg][sl] = int'(y);
            end
            OP_DEFINE_REGION:
            begin
                mir_cnt[rg] = (tot > DEF_MAX_CORNERS) ? DEF_MAX_CORNERS : int'(tot);
            end
            default:
            begin
            end
        endcase
        items_sent++;
    endtask

    task automatic put_vertex(input int r, input int s, input int x, input int y);
        send_item(OP_WRITE_VERTEX, REGION_W'(r), SLOT_W'(s), COORD_BITS'(x), COORD_BITS'(y),
                  TOTAL_W'($urandom), YIELD_W'($urandom));
    endtask

    task automatic define_region(input int r, input int tot, input int yv);
        send_item(OP_DEFINE_REGION, REGION_W'(r), SLOT_W'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), TOTAL_W'(tot), YIELD_W'(yv));
    endtask

    task automatic query(input int x, input int y);
        send_item(OP_QUERY, REGION_W'($urandom), SLOT_W'($urandom), COORD_BITS'(x),
                  COORD_BITS'(y), TOTAL_W'($urandom), YIELD_W'($urandom));
    endtask

    task automatic wait_quiet();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (class_backlog != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic program_regions(input int value);
        logic took;
        wait_quiet();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= CFG_W'(value);
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
        cfg_ch.valid <= 1'b0;
    endtask

    // convex polygon from points on a circle
    task automatic build_region();
        int  r;
        int  n;
        int  k;
        int  cx;
        int  cy;
        int  rad;
        int  tot;
        real ang;
        real phase;
        r = $urandom_range(0, 3);
        n = $urandom_range(MIN_CORNERS, DEF_MAX_CORNERS);
        if ($urandom_range(0, 9) == 0)
        begin
            cx  = 0;
            cy  = 0;
            rad = 32000;
        end
        else
        begin
            cx  = int'($urandom_range(0, 58000)) - 29000;
            cy  = int'($urandom_range(0, 58000)) - 29000;
            rad = $urandom_range(2, 3000);
        end
        phase = $urandom_range(0, 359) * TWO_PI / 360.0;
        for (k = 0; k < n; k++)
        begin
            ang = phase + TWO_PI * k / n;
            put_vertex(r, k, int'(cx + rad * $cos(ang)), int'(cy + rad * $sin(ang)));
        end
        tot = n;
        if (n == DEF_MAX_CORNERS && $urandom_range(0, 2) == 0)
        begin
            tot = $urandom_range(9, 15);
        end
        define_region(r, tot, $urandom_range(0, 65535));
    endtask

    task automatic pick_query();
        int kind;
        int r;
        int n;
        int s;
        int t;
        int k;
        int px;
        int py;
        int ends [4];
        ends = '{-32768, 32767, 0, -1};
        kind = $urandom_range(0, 9);
        r = $urandom_range(0, 3);
        n = mir_cnt[r];
        if (n < MIN_CORNERS && kind < 5)
        begin
            kind = 5;
        end
        s = (n > 0) ? $urandom_range(0, n - 1) : 0;
        t = (s + 1 == n) ? 0 : s + 1;
        case (kind)
            0, 1:
            begin
                px = 0;
                py = 0;
                for (k = 0; k < n; k++)
                begin
                    px += mir_x[r][k];
                    py += mir_y[r][k];
                end
                px = px / n;
                py = py / n;
                if (kind == 1)
                begin
                    px += int'($urandom_range(0, 40)) - 20;
                    py += int'($urandom_range(0, 40)) - 20;
                end
            end
            2:
            begin
                px = mir_x[r][s];
                py = mir_y[r][s];
            end
            3:
            begin
                px = (mir_x[r][s] + mir_x[r][t]) / 2;
                py = (mir_y[r][s] + mir_y[r][t]) / 2;
            end
            4:
            begin
                // mirror of the near end through the far end of an edge, on its line
                px = 2 * mir_x[r][t] - mir_x[r][s];
                py = 2 * mir_y[r][t] - mir_y[r][s];
            end
            5, 6, 7:
            begin
                px = int'($urandom_range(0, 65535)) - 32768;
                py = int'($urandom_range(0, 65535)) - 32768;
            end
            default:
            begin
                px = ends[$urandom_range(0, 3)];
                py = ends[$urandom_range(0, 3)];
            end
        endcase
        px = (px > 32767) ? 32767 : ((px < -32768) ? -32768 : px);
        py = (py > 32767) ? 32767 : ((py < -32768) ? -32768 : py);
        query(px, py);
    endtask

    task automatic random_step();
        int pick;
        int r;
        int tot;
        int eff;
        int need;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            build_region();
        end
        else if (pick < 75)
        begin
            pick_query();
        end
        else if (pick < 85)
        begin
            put_vertex($urandom_range(0, 3), $urandom_range(0, 7), $urandom, $urandom);
        end
        else if (pick < 94)
        begin
            // counts of MIN_CORNERS or more only where all their vertices have been written
            r    = $urandom_range(0, 3);
            tot  = $urandom_range(0, 15);
            eff  = (tot > DEF_MAX_CORNERS) ? DEF_MAX_CORNERS : tot;
            need = (1 << eff) - 1;
            if (eff >= MIN_CORNERS && (int'(written[r]) & need) != need)
            begin
                tot = $urandom_range(0, MIN_CORNERS - 1);
            end
            define_region(r, tot, $urandom);
        end
        else
        begin
            send_item(OP_UNUSED, REGION_W'($urandom), SLOT_W'($urandom),
                      COORD_BITS'($urandom), COORD_BITS'($urandom),
                      TOTAL_W'($urandom), YIELD_W'($urandom));
        end
    endtask

    initial
    begin
        int ph;
        int target;
        int plan [10];
        plan = '{1, 0, 7, 2, 3, 5, 4, 6, 0, 4};
        plan[8] = $urandom_range(0, 7);
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = OP_WRITE_VERTEX;
        item_ch.region       = '0;
        item_ch.vertex_slot  = '0;
        item_ch.coord_x      = '0;
        item_ch.coord_y      = '0;
        item_ch.corner_total = '0;
        item_ch.yield_value  = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        program_regions(DEF_MAX_REGIONS);

        // triangle over the whole coordinate range
        put_vertex(0, 0, -32768, -32768);
        put_vertex(0, 1, 32767, -32768);
        put_vertex(0, 2, -32768, 32767);
        define_region(0, 3, 16'hFFFF);
        query(-100, -100);
        query(32767, 32767);
        query(-32768, -32768);
        query(0, -32768);
        query(-1, 0);
        // too few vertices
        define_region(1, 2, 16'h1234);
        put_vertex(2, 0, 10, 10);
        put_vertex(2, 1, 20, 10);
        put_vertex(2, 2, 20, 20);
        put_vertex(2, 3, 10, 20);
        define_region(2, 4, 16'h0100);
        query(15, 15);
        query(25, 10);
        query(5, 10);
        send_item(OP_UNUSED, 2'd2, 3'd7, 16'sd15, 16'sd15, 4'd15, 16'hFFFF);
        // collinear vertices
        put_vertex(3, 0, 0, 100);
        put_vertex(3, 1, 50, 100);
        put_vertex(3, 2, 100, 100);
        define_region(3, 3, 16'hABCD);
        query(50, 100);
        query(200, 100);
        query(200, 101);

        for (ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
            begin
                calm = 1'b1;
            end
            program_regions(plan[ph]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                random_step();
            end
        end

        wait_quiet();
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/crpc_pkg.sv
rtl/crpc_intf.sv
rtl/crpc_datapath.sv
rtl/crpc_controller.sv
rtl/convex_region_point_classifier.sv
tb/sv/crpc_result_checker.sv
tb/sv/tb_top.sv
